/* src/tccw_pkg.sv */
package tccw_pkg;

  // Screen geometry
  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int CELL_COUNT   = COLUMNS * ROWS;
  localparam int SCROLL_COUNT = COLUMNS * (ROWS - 1);

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);

  // Field widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int LOC_W  = 11;
  localparam int CELL_W = 16;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam int TAB_STEP = 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CHR_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CHR_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CHR_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CHR_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CHR_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CHR_PRINT_HI = 8'h7F;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, BLANK_CHAR};

  // Controller to datapath
  typedef struct packed {
    logic exec;        // run the latched item
    logic scroll_step; // one step of the row copy
    logic fill_step;   // blank one cell
    logic fill_reset;  // blank with the power-on attribute
    logic out_load;    // load the result word
  } tccw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] item_cmd;
    logic             scroll_need;
    logic             scroll_last;
    logic             fill_last;
    logic             out_free;
  } tccw_stat_t;

endpackage

/* src/text_console_char_writer_unit.sv */
// Text console, 80 columns by 25 rows of 16-bit cells (attribute high byte,
// character low byte), with a cursor.
// Input words (in_*): cmd selects put character, read cell or clear screen.
// A put interprets BS, TAB, CR and LF, writes bytes 0x20..0x7F at the cursor
// and advances it, wrapping at the last column and scrolling at the last row.
// Every input word yields exactly one output word (out_*) with the cursor
// location after the command and, for an on-screen read, the cell contents (else zero).
// The cfg_* channel writes the attribute byte used for written and blank
// cells; it is always ready, and the user must write it only while the block
// is idle: the block itself does not enforce this. A put, read or unused
// command passes through EXEC and DONE into the output register, and the
// next word is taken back in IDLE. A put that scrolls adds a pass over the
// cell memory's single write port: the last 24 rows are copied up one row,
// then the bottom row is blanked. A clear blanks all 2000 cells, one per
// cycle. One word is worked on at a time; the memory's one write port sets
// the scroll and clear times. Reset: the cursor homes and a pass blanks
// every cell to 0x0F20; in_tready stays low during that pass.
// Stall: a finished word waits in the output register; the block takes the
// next input word meanwhile and holds its result until the register frees.
module text_console_char_writer_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [1:0] cmd, [9:2] char_code, [20:10] cell_address
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tccw_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: [10:0] cursor_location, [26:11] cell_value
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tccw_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // cfg_data: text_attribute
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tccw_pkg::ATTR_W-1:0]         cfg_data
);

  tccw_pkg::tccw_cmd_t  cmd;
  tccw_pkg::tccw_stat_t st;

  logic                         item_load;
  logic [tccw_pkg::LOC_W-1:0]   out_loc;
  logic [tccw_pkg::CELL_W-1:0]  out_cell;

  // Attribute register takes a word every cycle.
  assign cfg_ready = 1'b1;
  assign item_load = in_tvalid && in_tready;

  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  tccw_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_load    (item_load),
    .item_cmd_in  (in_tdata[1:0]),
    .item_char_in (in_tdata[9:2]),
    .item_addr_in (in_tdata[20:10]),
    .cfg_load     (cfg_valid && cfg_ready),
    .cfg_attr     (cfg_data),
    .cmd          (cmd),
    .st           (st),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_loc      (out_loc),
    .out_cell     (out_cell)
  );

  // Pack the result word; pad the top bits with zeros.
  assign out_tdata = {
    (tccw_pkg::OUT_TDATA_W - tccw_pkg::LOC_W - tccw_pkg::CELL_W)'(0),
    out_cell, out_loc
  };

  // Blanking pass follows reset: no word is taken in the next cycle.
  a_init_blocks: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input accepted right after reset");

  // One word at a time: after an accept the block is busy.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a word is in work");

  // Cursor location always lies on the screen.
  a_loc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10:0] < tccw_pkg::CELL_COUNT))
    else $error("cursor location off screen");

  // A result appears only after the work of a command, never with its accept.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !out_tvalid) |=> !out_tvalid)
    else $error("result word with no work done");

endmodule

/* src/tccw_ctrl.sv */
module tccw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tccw_pkg::tccw_stat_t st,
  output tccw_pkg::tccw_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_EXEC   = 6'b000100,
    S_SCROLL = 6'b001000,
    S_FILL   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.fill_step  = 1'b1;
        cmd.fill_reset = 1'b1;
        if (st.fill_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (st.item_cmd)
          tccw_pkg::CMD_PUT:   state_nxt = st.scroll_need ? S_SCROLL : S_DONE;
          tccw_pkg::CMD_CLEAR: state_nxt = S_FILL;
          default:             state_nxt = S_DONE;
        endcase
      end
      S_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (st.scroll_last) state_nxt = S_FILL;
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (st.fill_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output word is free
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

/* src/tccw_dp.sv */
module tccw_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                item_load,
  input  logic [tccw_pkg::CMD_W-1:0]          item_cmd_in,
  input  logic [tccw_pkg::CHAR_W-1:0]         item_char_in,
  input  logic [tccw_pkg::LOC_W-1:0]          item_addr_in,
  input  logic                                cfg_load,
  input  logic [tccw_pkg::ATTR_W-1:0]         cfg_attr,
  input  tccw_pkg::tccw_cmd_t                 cmd,
  output tccw_pkg::tccw_stat_t                st,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [tccw_pkg::LOC_W-1:0]          out_loc,
  output logic [tccw_pkg::CELL_W-1:0]         out_cell
);

  localparam int CW1 = tccw_pkg::COL_W + 1;
  localparam int RW1 = tccw_pkg::ROW_W + 1;
  localparam int AW  = tccw_pkg::ADDR_W;
  localparam logic [AW-1:0] COLS_A   = AW'(tccw_pkg::COLUMNS);
  localparam logic [AW-1:0] SCROLL_A = AW'(tccw_pkg::SCROLL_COUNT);
  localparam logic [AW-1:0] LAST_A   = AW'(tccw_pkg::CELL_COUNT - 1);

  logic [tccw_pkg::CELL_W-1:0] mem [tccw_pkg::CELL_COUNT];

  logic [tccw_pkg::CMD_W-1:0]  item_cmd_r;
  logic [tccw_pkg::CHAR_W-1:0] item_char_r;
  logic [tccw_pkg::LOC_W-1:0]  item_addr_r;
  logic [tccw_pkg::ATTR_W-1:0] attr_r;
  logic [tccw_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [tccw_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [AW-1:0]               ptr_r, ptr_nxt;
  logic [tccw_pkg::CELL_W-1:0] rdata_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [tccw_pkg::LOC_W-1:0]  out_loc_r;
  logic [tccw_pkg::CELL_W-1:0] out_cell_r;

  logic [CW1-1:0]              col_n;
  logic [RW1-1:0]              row_n;
  logic                        row_inc;
  logic                        wr_put;
  logic                        scroll_need;
  logic [AW-1:0]               loc;
  logic                        addr_ok;
  logic                        is_put, is_read, is_clear;
  logic                        wr_en, rd_en;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [tccw_pkg::CELL_W-1:0] wr_data;

  assign is_put   = (item_cmd_r == tccw_pkg::CMD_PUT);
  assign is_read  = (item_cmd_r == tccw_pkg::CMD_READ);
  assign is_clear = (item_cmd_r == tccw_pkg::CMD_CLEAR);
  assign loc      = AW'(AW'(row_r) * COLS_A) + AW'(col_r);
  assign addr_ok  = (item_addr_r < tccw_pkg::CELL_COUNT);

  // Cursor motion for a put
  always_comb begin
    col_n   = {1'b0, col_r};
    row_inc = 1'b0;
    wr_put  = 1'b0;
    case (item_char_r)
      tccw_pkg::CHR_BS: begin
        if (col_r != '0) col_n = col_n - CW1'(1);
      end
      tccw_pkg::CHR_TAB: begin
        col_n = (col_n + CW1'(tccw_pkg::TAB_STEP)) & ~CW1'(tccw_pkg::TAB_STEP - 1);
      end
      tccw_pkg::CHR_CR: begin
        col_n = '0;
      end
      tccw_pkg::CHR_LF: begin
        col_n   = '0;
        row_inc = 1'b1;
      end
      default: begin
        if (item_char_r inside {[tccw_pkg::CHR_PRINT_LO:tccw_pkg::CHR_PRINT_HI]}) begin
          wr_put = 1'b1;
          col_n  = col_n + CW1'(1);
        end
      end
    endcase
    // wrap at the right edge
    if (col_n >= CW1'(tccw_pkg::COLUMNS)) begin
      col_n   = '0;
      row_inc = 1'b1;
    end
    row_n       = {1'b0, row_r} + RW1'(row_inc);
    scroll_need = (row_n >= RW1'(tccw_pkg::ROWS));
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.exec && is_put) begin
      col_nxt = col_n[tccw_pkg::COL_W-1:0];
      row_nxt = scroll_need ? tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1) : row_n[tccw_pkg::ROW_W-1:0];
    end else if (cmd.exec && is_clear) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  // Sweep pointer: a scroll reads one row ahead and writes one step behind
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.exec) begin
      ptr_nxt = '0;
    end else if (cmd.scroll_step) begin
      ptr_nxt = st.scroll_last ? ptr_r : ptr_r + AW'(1);
    end else if (cmd.fill_step) begin
      ptr_nxt = ptr_r + AW'(1);
    end
  end

  // Memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = {attr_r, tccw_pkg::BLANK_CHAR};
    rd_en   = 1'b0;
    rd_addr = ptr_r + COLS_A;
    if (cmd.exec) begin
      wr_en   = is_put && wr_put;
      wr_addr = loc;
      wr_data = {attr_r, item_char_r};
      rd_en   = is_read;
      rd_addr = item_addr_r[AW-1:0];
    end else if (cmd.scroll_step) begin
      wr_en   = (ptr_r != '0);
      wr_addr = ptr_r - AW'(1);
      wr_data = rdata_r;
      rd_en   = !st.scroll_last;
    end else if (cmd.fill_step) begin
      wr_en   = 1'b1;
      wr_data = cmd.fill_reset ? tccw_pkg::RESET_BLANK : {attr_r, tccw_pkg::BLANK_CHAR};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= tccw_pkg::RESET_ATTR;
      col_r       <= '0;
      row_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_load) attr_r <= cfg_attr;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      item_cmd_r  <= item_cmd_in;
      item_char_r <= item_char_in;
      item_addr_r <= item_addr_in;
    end
    if (cmd.out_load) begin
      out_loc_r  <= tccw_pkg::LOC_W'(loc);
      out_cell_r <= (is_read && addr_ok) ? rdata_r : '0;
    end
  end

  assign st.item_cmd    = item_cmd_r;
  assign st.scroll_need = scroll_need;
  assign st.scroll_last = (ptr_r == SCROLL_A);
  assign st.fill_last   = (ptr_r == LAST_A);
  assign st.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_loc   = out_loc_r;
  assign out_cell  = out_cell_r;

endmodule

/* sim/tb_top.sv */
module tb_top;
  import tccw_pkg::*;

  // cmd 3 has no meaning in the block; it must change nothing
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // Generous cycle budget: reset pass plus every word scrolling and stalling
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int RANDOM_WORDS = 220;

  typedef struct {
    logic [LOC_W-1:0]  loc;
    logic [CELL_W-1:0] cell_val;
  } console_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ATTR_W-1:0] cfg_data = '0;

  text_console_char_writer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Console image kept by the bench: screen cells, cursor, attribute byte
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0] screen [CELL_COUNT];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [ATTR_W-1:0] attr;

  // Replies owed by the block, oldest first
  console_reply_t reply_q [$];

  int unsigned words_sent;
  int unsigned reads_sent;
  int unsigned scrolls_seen;
  int unsigned clears_seen;
  int unsigned attr_settings;
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          in_steady;
  bit          out_steady;
  int unsigned out_hold;
  console_reply_t owed;

  // Blank every cell from the given index to the end of the screen
  function automatic void blank_from(int unsigned from);
    for (int unsigned i = from; i < CELL_COUNT; i++) screen[i] = {attr, BLANK_CHAR};
  endfunction

  function automatic void put_char(logic [CHAR_W-1:0] c);
    if (c == CHR_BS) begin
      if (cur_col != 0) cur_col--;
    end else if (c == CHR_TAB) begin
      cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
    end else if (c == CHR_CR) begin
      cur_col = 0;
    end else if (c == CHR_LF) begin
      cur_col = 0;
      cur_row++;
    end else if (c >= CHR_PRINT_LO && c <= CHR_PRINT_HI) begin
      screen[cur_row * COLUMNS + cur_col] = {attr, c};
      cur_col++;
    end
    // wrap past the last column, then scroll past the last row
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= ROWS) begin
      for (int unsigned i = 0; i < SCROLL_COUNT; i++) screen[i] = screen[i + COLUMNS];
      blank_from(SCROLL_COUNT);
      cur_row = ROWS - 1;
      scrolls_seen++;
    end
  endfunction

  // Apply one command to the image and return the reply it owes
  function automatic console_reply_t run_console_cmd(logic [CMD_W-1:0] cmd,
                                                     logic [CHAR_W-1:0] ch,
                                                     logic [LOC_W-1:0] addr);
    console_reply_t r;
    r.cell_val = '0;
    case (cmd)
      CMD_PUT: put_char(ch);
      CMD_READ: begin
        reads_sent++;
        if (addr < CELL_COUNT) r.cell_val = screen[addr];
      end
      CMD_CLEAR: begin
        blank_from(0);
        cur_col = 0;
        cur_row = 0;
        clears_seen++;
      end
      default: ;
    endcase
    r.loc = cur_row * COLUMNS + cur_col;
    return r;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0d: %s", cycle_count, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Idle the input after a word: mostly none or short, now and then long
  task automatic in_gap();
    int unsigned pick;
    int unsigned len;
    if (in_steady) return;
    pick = $urandom_range(0, 99);
    if (pick < 60) len = 0;
    else if (pick < 90) len = $urandom_range(1, 3);
    else len = $urandom_range(8, 40);
    if (len != 0) begin
      in_tvalid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // Offer one word and hold it until the block takes it
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                          input logic [LOC_W-1:0] addr);
    in_tdata  <= {3'b000, addr, ch, cmd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    reply_q.push_back(run_console_cmd(cmd, ch, addr));
    words_sent++;
    in_gap();
  endtask

  task automatic put(input logic [CHAR_W-1:0] ch);
    send_cmd(CMD_PUT, ch, LOC_W'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input logic [LOC_W-1:0] addr);
    send_cmd(CMD_READ, CHAR_W'($urandom_range(0, 255)), addr);
  endtask

  // Drop valid and hold off until every owed reply is back
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Change the attribute only with the block idle
  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    drain_replies();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    attr = value;
    attr_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall at random, with steady stretches
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_tready <= 1'b0;
      out_hold   <= out_hold - 1;
    end else if (!out_steady && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      out_hold   <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each accepted output word with the oldest owed reply
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_q.size() == 0) begin
        note_failure($sformatf("unexpected output word %h", out_tdata));
      end else begin
        owed = reply_q.pop_front();
        if (out_tdata[LOC_W-1:0] !== owed.loc)
          note_failure($sformatf("cursor_location expected %0d actual %0d",
                                 owed.loc, out_tdata[LOC_W-1:0]));
        if (out_tdata[LOC_W +: CELL_W] !== owed.cell_val)
          note_failure($sformatf("cell_value expected %h actual %h",
                                 owed.cell_val, out_tdata[LOC_W +: CELL_W]));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("text_console_char_writer_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Power-on contents: first and last cell, an address past the screen, cmd 3
  task automatic test_power_on_cells();
    read_cell(0);
    read_cell(CELL_COUNT - 1);
    read_cell(11'h7FF);
    send_cmd(CMD_UNUSED, 8'hFF, 11'h7FF);
  endtask

  // Printable limits are written; control and high bytes are dropped
  task automatic test_put_characters();
    put(8'h41);
    put(CHR_PRINT_LO);
    put(CHR_PRINT_HI);
    put(8'h80);
    put(8'hFF);
    put(8'h00);
    put(8'h1F);
  endtask

  // Backspace, also at column zero, tab, carriage return, line feed, clear
  task automatic test_cursor_controls();
    put(CHR_BS);
    put(CHR_CR);
    put(CHR_BS);
    put(CHR_TAB);
    put(CHR_LF);
    send_cmd(CMD_CLEAR, 8'h00, 11'h000);
  endtask

  // Tab from the last stop wraps to the next row
  task automatic test_tab_wrap();
    repeat (COLUMNS / TAB_STEP) put(CHR_TAB);
    read_cell(COLUMNS - 1);
  endtask

  task automatic line_feeds(input int unsigned count);
    repeat (count) put(CHR_LF);
  endtask

  // One random stretch of traffic, mostly well-formed text
  task automatic random_sequence();
    int unsigned kind;
    int unsigned len;
    int unsigned base;
    logic [CHAR_W-1:0] ctrl [4];
    ctrl = '{CHR_BS, CHR_TAB, CHR_CR, CHR_LF};
    if ($urandom_range(0, 99) < 15) in_steady = !in_steady;
    if ($urandom_range(0, 99) < 15) out_steady = !out_steady;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      // text with a sprinkle of cursor controls
      len = $urandom_range(1, 60);
      repeat (len) begin
        if ($urandom_range(0, 99) < 8) put(ctrl[$urandom_range(0, 3)]);
        else put(CHAR_W'($urandom_range(CHR_PRINT_LO, CHR_PRINT_HI)));
      end
    end else if (kind < 60) begin
      line_feeds($urandom_range(3, 26));
    end else if (kind < 80) begin
      // reads: near the cursor, anywhere on screen, or anywhere the field allows
      len = $urandom_range(1, 6);
      repeat (len) begin
        kind = $urandom_range(0, 99);
        base = cur_row * COLUMNS + cur_col;
        if (kind < 50) begin
          len = $urandom_range(0, 160);
          read_cell(LOC_W'((base > len) ? base - len : 0));
        end else if (kind < 85) begin
          read_cell(LOC_W'($urandom_range(0, CELL_COUNT - 1)));
        end else begin
          read_cell(LOC_W'($urandom_range(0, 2047)));
        end
      end
    end else if (kind < 83) begin
      send_cmd(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)), LOC_W'($urandom_range(0, 2047)));
    end else begin
      // noise: any command, any byte, any address
      len = $urandom_range(1, 8);
      repeat (len)
        send_cmd(CMD_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                 LOC_W'($urandom_range(0, 2047)));
    end
  endtask

  // One attribute setting, opened by a screenful of line feeds so it scrolls
  task automatic test_random_traffic(input logic [ATTR_W-1:0] value,
                                     input int unsigned count);
    int unsigned stop_at;
    write_attribute(value);
    stop_at = words_sent + count;
    line_feeds(ROWS);
    while (words_sent < stop_at) random_sequence();
  endtask

  // Pause the sender until every reply is back, then carry on
  task automatic test_sender_pause();
    drain_replies();
    repeat ($urandom_range(1, 20)) @(posedge clk);
    random_sequence();
  endtask

  initial begin
    attr       = RESET_ATTR;
    cur_col    = 0;
    cur_row    = 0;
    in_steady  = 1'b0;
    out_steady = 1'b0;
    out_hold   = 0;
    blank_from(0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_power_on_cells();
    test_put_characters();
    test_cursor_controls();
    test_tab_wrap();

    test_random_traffic(8'h00, RANDOM_WORDS / 4);
    test_random_traffic(8'hFF, RANDOM_WORDS / 4);
    test_sender_pause();
    test_random_traffic(ATTR_W'($urandom_range(0, 255)), RANDOM_WORDS / 4);
    test_random_traffic(ATTR_W'($urandom_range(0, 255)), RANDOM_WORDS / 4);

    // Let any stray word surface; a scrolling put is the longest the block works
    drain_replies();
    repeat (CELL_COUNT + 100) @(posedge clk);
    if (reply_q.size() != 0)
      note_failure($sformatf("%0d replies never arrived", reply_q.size()));

    $display("Covered %0d commands: %0d reads, %0d scrolls, %0d clears",
             words_sent, reads_sent, scrolls_seen, clears_seen);
    $display("Attribute written %0d times; %0d failures logged", attr_settings, fail_count);
    if (fail_count == 0) begin
      $display("text_console_char_writer_unit verification clean");
    end else begin
      $display("text_console_char_writer_unit verification failed");
    end
    $finish;
  end

endmodule
